### rtl/core/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, context bit positions and character codes for the C lexical
// context tracker.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int CHAR_W = 21;
    localparam int CTX_W  = 9;

    localparam int CTX_ESCAPE  = 0;
    localparam int CTX_BLOCK   = 1;
    localparam int CTX_LINE    = 2;
    localparam int CTX_DQUOTE  = 3;
    localparam int CTX_SQUOTE  = 4;
    localparam int CTX_PREPROC = 5;
    localparam int CTX_INDENT  = 6;
    localparam int CTX_NEWLINE = 7;
    localparam int CTX_WORD    = 8;

    localparam logic [CTX_W-1:0] CTX_RESET      = 9'h080;
    localparam logic [CTX_W-1:0] CTX_INNER_MASK = 9'h03F;
    localparam logic [CTX_W-1:0] CTX_NONE       = 9'h000;
    localparam logic [CTX_W-1:0] CTX_ONLY_BLOCK  = 9'h002;
    localparam logic [CTX_W-1:0] CTX_ONLY_DQUOTE = 9'h008;
    localparam logic [CTX_W-1:0] CTX_ONLY_SQUOTE = 9'h010;

    localparam logic [CHAR_W-1:0] CH_NUL        = 21'h00000;
    localparam logic [CHAR_W-1:0] CH_TAB        = 21'h00009;
    localparam logic [CHAR_W-1:0] CH_LF         = 21'h0000A;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 21'h00020;
    localparam logic [CHAR_W-1:0] CH_DQUOTE     = 21'h00022;
    localparam logic [CHAR_W-1:0] CH_HASH       = 21'h00023;
    localparam logic [CHAR_W-1:0] CH_SQUOTE     = 21'h00027;
    localparam logic [CHAR_W-1:0] CH_STAR       = 21'h0002A;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 21'h0002F;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 21'h0005C;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 21'h0005F;

    localparam logic [2:0] COL_NONE    = 3'd0;
    localparam logic [2:0] COL_STRING  = 3'd1;
    localparam logic [2:0] COL_BLOCK   = 3'd2;
    localparam logic [2:0] COL_LINE    = 3'd3;
    localparam logic [2:0] COL_PREPROC = 3'd4;

    localparam logic LUT_KEYWORD = 1'b0;
    localparam logic LUT_PREPROC = 1'b1;

    typedef struct packed {
        logic [1:0] consumed_length;
        logic [2:0] colour_class;
        logic       lookup_request;
        logic       lookup_table;
    } mark_t;

    function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
        return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
               (c >= 21'h30 && c <= 21'h39) || (c == CH_UNDERSCORE);
    endfunction

endpackage

### rtl/core/clt_step.sv
// ----------------------------------------------------------------------------
// clt_step
// Context update and colour mark for one character: combinational.
// ----------------------------------------------------------------------------
module clt_step (
    input  logic [clt_pkg::CHAR_W-1:0] cur_char,
    input  logic [clt_pkg::CHAR_W-1:0] nxt_char,
    input  logic [clt_pkg::CTX_W-1:0]  ctx_before,
    output logic [clt_pkg::CTX_W-1:0]  ctx_after,
    output clt_pkg::mark_t             mark
);

    logic [clt_pkg::CTX_W-1:0] inner;
    logic [clt_pkg::CTX_W-1:0] after;
    logic [clt_pkg::CTX_W-1:0] either;

    always_comb
    begin
        inner = ctx_before & clt_pkg::CTX_INNER_MASK;
        after = ctx_before;
        mark.consumed_length = 2'd1;
        mark.colour_class    = clt_pkg::COL_NONE;
        mark.lookup_request  = 1'b0;
        mark.lookup_table    = clt_pkg::LUT_KEYWORD;

        if (inner[clt_pkg::CTX_ESCAPE])
        begin
            after[clt_pkg::CTX_ESCAPE] = 1'b0;
        end
        else if (cur_char == clt_pkg::CH_SLASH)
        begin
            if (inner == clt_pkg::CTX_NONE && nxt_char == clt_pkg::CH_STAR)
            begin
                mark.consumed_length = 2'd2;
                after[clt_pkg::CTX_BLOCK] = 1'b1;
            end
            else if (inner == clt_pkg::CTX_NONE && nxt_char == clt_pkg::CH_SLASH)
            begin
                mark.consumed_length = 2'd2;
                after[clt_pkg::CTX_LINE] = 1'b1;
            end
        end
        else if (cur_char == clt_pkg::CH_STAR)
        begin
            if (nxt_char == clt_pkg::CH_SLASH && inner == clt_pkg::CTX_ONLY_BLOCK)
            begin
                mark.consumed_length = 2'd2;
                after[clt_pkg::CTX_BLOCK] = 1'b0;
            end
        end
        else if (cur_char == clt_pkg::CH_BACKSLASH)
        begin
            if (inner == clt_pkg::CTX_ONLY_DQUOTE || inner == clt_pkg::CTX_ONLY_SQUOTE)
                after[clt_pkg::CTX_ESCAPE] = 1'b1;
        end
        else if (cur_char == clt_pkg::CH_DQUOTE)
        begin
            if (inner == clt_pkg::CTX_NONE)
                after[clt_pkg::CTX_DQUOTE] = 1'b1;
            else if (inner == clt_pkg::CTX_ONLY_DQUOTE)
                after[clt_pkg::CTX_DQUOTE] = 1'b0;
        end
        else if (cur_char == clt_pkg::CH_SQUOTE)
        begin
            if (inner == clt_pkg::CTX_NONE)
                after[clt_pkg::CTX_SQUOTE] = 1'b1;
            else if (inner == clt_pkg::CTX_ONLY_SQUOTE)
                after[clt_pkg::CTX_SQUOTE] = 1'b0;
        end
        else if (cur_char == clt_pkg::CH_HASH)
        begin
            if (ctx_before[clt_pkg::CTX_INDENT] || ctx_before[clt_pkg::CTX_NEWLINE])
                after[clt_pkg::CTX_PREPROC] = 1'b1;
        end

        if (ctx_before[clt_pkg::CTX_NEWLINE])
        begin
            after[clt_pkg::CTX_INDENT]  = 1'b1;
            after[clt_pkg::CTX_NEWLINE] = 1'b0;
        end
        if (cur_char != clt_pkg::CH_TAB && cur_char != clt_pkg::CH_SPACE)
            after[clt_pkg::CTX_INDENT] = 1'b0;
        // end of text behaves as a newline
        if (cur_char == clt_pkg::CH_NUL || cur_char == clt_pkg::CH_LF)
        begin
            after[clt_pkg::CTX_NEWLINE] = 1'b1;
            after[clt_pkg::CTX_PREPROC] = 1'b0;
            after[clt_pkg::CTX_DQUOTE]  = 1'b0;
            after[clt_pkg::CTX_SQUOTE]  = 1'b0;
            after[clt_pkg::CTX_LINE]    = 1'b0;
        end
        after[clt_pkg::CTX_WORD] = clt_pkg::is_word_char(cur_char);

        either = ctx_before | after;
        if (either[clt_pkg::CTX_DQUOTE] || either[clt_pkg::CTX_SQUOTE])
        begin
            mark.colour_class = clt_pkg::COL_STRING;
        end
        else if (either[clt_pkg::CTX_BLOCK])
        begin
            mark.colour_class = clt_pkg::COL_BLOCK;
        end
        else if (either[clt_pkg::CTX_LINE])
        begin
            mark.colour_class = clt_pkg::COL_LINE;
        end
        else if (after[clt_pkg::CTX_INDENT])
        begin
            mark.consumed_length = 2'd0;
        end
        else if (after[clt_pkg::CTX_PREPROC])
        begin
            // first visible character after '#' starts the directive name
            if (cur_char > clt_pkg::CH_SPACE && ctx_before[clt_pkg::CTX_PREPROC])
            begin
                after[clt_pkg::CTX_PREPROC] = 1'b0;
                mark.consumed_length = 2'd0;
                mark.lookup_request  = 1'b1;
                mark.lookup_table    = clt_pkg::LUT_PREPROC;
            end
            else
            begin
                mark.consumed_length = 2'd1;
                mark.colour_class    = clt_pkg::COL_PREPROC;
            end
        end
        else
        begin
            mark.consumed_length = 2'd0;
            if (!ctx_before[clt_pkg::CTX_WORD] && after[clt_pkg::CTX_WORD])
                mark.lookup_request = 1'b1;
        end

        ctx_after = after;
    end

endmodule

### rtl/core/c_lexical_context_tracker.sv
// ----------------------------------------------------------------------------
// c_lexical_context_tracker
// Tracks C lexical context over a character stream and gives one colour mark,
// with a keyword or directive lookup request where one starts, per character.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  char    | in        | char_valid / char_ready | current_char, next_char
//  mark    | out       | mark_valid / mark_ready | consumed_length, colour_class,
//          |           |                         | lookup_request, lookup_table
//
//  One character per cycle unless the mark stalls; each goes through the input, then result register.
//  The context register updates as a character moves from the input register
//  into the result register, a loop through clt_step back into the context register.
//  Reset leaves both stages empty and the context at newline only.
//  A stalled mark holds the result register; the input register refills as
//  soon as the result moves on.
// ----------------------------------------------------------------------------
module c_lexical_context_tracker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_ready,
    input  logic [clt_pkg::CHAR_W-1:0] current_char,
    input  logic [clt_pkg::CHAR_W-1:0] next_char,
    output logic                       mark_valid,
    input  logic                       mark_ready,
    output logic [1:0]                 consumed_length,
    output logic [2:0]                 colour_class,
    output logic                       lookup_request,
    output logic                       lookup_table
);

    logic                       in_valid_reg;
    logic [clt_pkg::CHAR_W-1:0] cur_reg;
    logic [clt_pkg::CHAR_W-1:0] nxt_reg;
    logic [clt_pkg::CTX_W-1:0]  ctx_reg;
    logic [clt_pkg::CTX_W-1:0]  ctx_next;
    logic                       out_valid_reg;
    clt_pkg::mark_t             mark_reg;
    clt_pkg::mark_t             mark_next;
    logic                       advance;
    logic                       take;

    assign advance    = !out_valid_reg || mark_ready;
    assign char_ready = !in_valid_reg || advance;
    assign take       = char_valid && char_ready;

    clt_step u_step (
        .cur_char   (cur_reg),
        .nxt_char   (nxt_reg),
        .ctx_before (ctx_reg),
        .ctx_after  (ctx_next),
        .mark       (mark_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= clt_pkg::CTX_RESET;
        end
        else
        begin
            if (char_ready)
                in_valid_reg <= char_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
                ctx_reg <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= current_char;
            nxt_reg <= next_char;
        end
        if (advance && in_valid_reg)
            mark_reg <= mark_next;
    end

    assign mark_valid      = out_valid_reg;
    assign consumed_length = mark_reg.consumed_length;
    assign colour_class    = mark_reg.colour_class;
    assign lookup_request  = mark_reg.lookup_request;
    assign lookup_table    = mark_reg.lookup_table;

    a_indent_newline_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctx_reg[clt_pkg::CTX_INDENT] && ctx_reg[clt_pkg::CTX_NEWLINE]))
        else $error("indent and newline context bits both set");

    a_lookup_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_valid && lookup_request) |->
        (consumed_length == 2'd0 && colour_class == clt_pkg::COL_NONE))
        else $error("lookup request carries a colour mark");

    a_table_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mark_valid && !lookup_request) |-> (lookup_table == clt_pkg::LUT_KEYWORD))
        else $error("lookup table selected without request");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> mark_valid)
        else $error("character lost between stages");

    a_ctx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid_reg && advance) |=> $stable(ctx_reg))
        else $error("context changed without a character");

endmodule
